>>> hdl/i2crs_pkg.sv
package i2crs_pkg;

	localparam int BUFFER_DEPTH_DEF = 16;

	// request types
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_EVENT = 1'b1;

	// bus event codes
	localparam logic [2:0] EV_START_SENT = 3'd0;
	localparam logic [2:0] EV_TX_SEL     = 3'd1;
	localparam logic [2:0] EV_BYTE_TXING = 3'd2;
	localparam logic [2:0] EV_BYTE_TXED  = 3'd3;
	localparam logic [2:0] EV_RX_SEL     = 3'd4;
	localparam logic [2:0] EV_BYTE_RXED  = 3'd5;

	// transmit kinds
	localparam logic [1:0] TX_NONE     = 2'd0;
	localparam logic [1:0] TX_ADDR_WR  = 2'd1;
	localparam logic [1:0] TX_ADDR_RD  = 2'd2;
	localparam logic [1:0] TX_DATA     = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] slave_address;
		logic [7:0] register_address;
		logic [4:0] read_count;
		logic       bus_busy;
		logic [2:0] event_code;
		logic [7:0] received_byte;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic       gen_start;
		logic       gen_stop;
		logic [1:0] tx_kind;
		logic [7:0] tx_byte;
		logic       ack_on;
		logic       buf_irq_on;
		logic       evt_irq_on;
		logic       store_valid;
		logic [3:0] store_index;
		logic [7:0] store_data;
		logic       done_res;
	} result_t;

	typedef struct packed {
		logic [7:0] target_address;
		logic [7:0] sub_address;
		logic [4:0] bytes_left;
		logic [3:0] write_position;
		logic       read_phase;
		logic       finished;
		logic       ack_enable;
		logic       buf_irq_enable;
		logic       evt_irq_enable;
	} state_t;

	localparam state_t STATE_RESET = '{
		target_address: 8'd0,
		sub_address:    8'd0,
		bytes_left:     5'd0,
		write_position: 4'd0,
		read_phase:     1'b0,
		finished:       1'b1,
		ack_enable:     1'b1,
		buf_irq_enable: 1'b0,
		evt_irq_enable: 1'b0
	};

endpackage

>>> hdl/i2crs_step.sv
module i2crs_step import i2crs_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	logic [4:0] left_dec;

	assign left_dec = cur.bytes_left - 5'd1;

	always_comb begin
		nxt = cur;
		res = '0;
		if (item.req_type == REQ_START) begin
			if (!item.bus_busy) begin
				nxt.target_address = item.slave_address;
				nxt.sub_address    = item.register_address;
				if (int'(item.read_count) > BUFFER_DEPTH) begin
					nxt.bytes_left = 5'(BUFFER_DEPTH);
				end else begin
					nxt.bytes_left = item.read_count;
				end
				nxt.write_position = 4'd0;
				nxt.read_phase     = 1'b0;
				nxt.finished       = 1'b0;
				nxt.ack_enable     = 1'b1;
				nxt.buf_irq_enable = 1'b1;
				nxt.evt_irq_enable = 1'b1;
				res.gen_start      = 1'b1;
				res.accepted       = 1'b1;
			end
		end else if (!cur.finished) begin
			case (item.event_code)
				EV_START_SENT: begin
					if (cur.read_phase) begin
						res.tx_kind = TX_ADDR_RD;
						res.tx_byte = cur.target_address | 8'h01;
					end else begin
						res.tx_kind = TX_ADDR_WR;
						res.tx_byte = cur.target_address & 8'hFE;
					end
				end
				EV_TX_SEL: begin
					res.tx_kind = TX_DATA;
					res.tx_byte = cur.sub_address;
					nxt.buf_irq_enable = 1'b0;
				end
				EV_BYTE_TXING: begin
					nxt.buf_irq_enable = 1'b0;
				end
				EV_BYTE_TXED: begin
					if (cur.bytes_left == 5'd0) begin
						res.gen_stop = 1'b1;
						nxt.evt_irq_enable = 1'b0;
						nxt.finished = 1'b1;
					end else begin
						nxt.read_phase = 1'b1;
						nxt.buf_irq_enable = 1'b1;
						res.gen_start = 1'b1;
					end
				end
				EV_RX_SEL: begin
					if (cur.bytes_left == 5'd1) begin
						nxt.ack_enable = 1'b0;
						res.gen_stop = 1'b1;
					end
				end
				EV_BYTE_RXED: begin
					if (cur.bytes_left != 5'd0) begin
						res.store_valid = 1'b1;
						res.store_index = cur.write_position;
						res.store_data  = item.received_byte;
						nxt.write_position = cur.write_position + 4'd1;
						nxt.bytes_left = left_dec;
						// one byte to go: NACK it and close with STOP
						if (left_dec == 5'd1) begin
							nxt.ack_enable = 1'b0;
							res.gen_stop = 1'b1;
						end else if (left_dec == 5'd0) begin
							nxt.finished = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.ack_on     = nxt.ack_enable;
		res.buf_irq_on = nxt.buf_irq_enable;
		res.evt_irq_on = nxt.evt_irq_enable;
		res.done_res   = nxt.finished;
	end

endmodule

>>> hdl/i2c_master_register_read_sequencer.sv
// Each word passes through the input register and then the result register.
// Throughput: one word per cycle unless out_ready stalls the output; the sequencer
// state and the result register update together at a single edge, so consecutive
// words never wait on each other.
// Reset (arst_n low, asynchronous): pipeline valids clear, sequencer goes idle with
// acknowledge enabled and both interrupts disabled.
module i2c_master_register_read_sequencer import i2crs_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] slave_address,
	input  logic [7:0] register_address,
	input  logic [4:0] read_count,
	input  logic       bus_busy,
	input  logic [2:0] event_code,
	input  logic [7:0] received_byte,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted,
	output logic       gen_start,
	output logic       gen_stop,
	output logic [1:0] tx_kind,
	output logic [7:0] tx_byte,
	output logic       ack_on,
	output logic       buf_irq_on,
	output logic       evt_irq_on,
	output logic       store_valid,
	output logic [3:0] store_index,
	output logic [7:0] store_data,
	output logic       done_res
);

	// Stage 1: input register holding one word.
	item_t   item_s1;
	logic    valid_s1;

	// Stage 2: result register, plus the sequencer state that it reflects.
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;

	state_t  state_nxt;
	result_t res_nxt;
	logic    adv_s2;
	logic    take_in;

	// The result register loads when a word waits and it is empty or being drained;
	// the input register refills at the same edge, so full rate holds under flow.
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign take_in  = in_valid && in_ready;

	// All per-word work: combinational compares, a decrement and selects on the state.
	i2crs_step #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed, qualified by the valids above.
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{
				req_type:         req_type,
				slave_address:    slave_address,
				register_address: register_address,
				read_count:       read_count,
				bus_busy:         bus_busy,
				event_code:       event_code,
				received_byte:    received_byte
			};
		end
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign accepted    = res_s2.accepted;
	assign gen_start   = res_s2.gen_start;
	assign gen_stop    = res_s2.gen_stop;
	assign tx_kind     = res_s2.tx_kind;
	assign tx_byte     = res_s2.tx_byte;
	assign ack_on      = res_s2.ack_on;
	assign buf_irq_on  = res_s2.buf_irq_on;
	assign evt_irq_on  = res_s2.evt_irq_on;
	assign store_valid = res_s2.store_valid;
	assign store_index = res_s2.store_index;
	assign store_data  = res_s2.store_data;
	assign done_res    = res_s2.done_res;

endmodule

>>> hdl/i2crs_checker.sv
module i2crs_checker import i2crs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       accepted,
	input logic       gen_start,
	input logic       gen_stop,
	input logic [1:0] tx_kind,
	input logic [7:0] tx_byte,
	input logic       ack_on,
	input logic       buf_irq_on,
	input logic       evt_irq_on,
	input logic       store_valid,
	input logic [3:0] store_index,
	input logic [7:0] store_data,
	input logic       done_res
);

	// stalled result word holds its tx byte, store data and done flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(store_data)
		&& $stable(done_res))
		else $error("result word changed while stalled");

	// a taken start request arms the transfer
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> gen_start && !gen_stop && ack_on && buf_irq_on
		&& evt_irq_on && !done_res && tx_kind == TX_NONE && !store_valid)
		else $error("start request result inconsistent");

	// store fields read zero unless a byte is stored
	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !store_valid |-> store_index == 4'd0 && store_data == 8'd0)
		else $error("store fields set without a store");

	// nothing to send means a zero tx byte
	a_tx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_kind == TX_NONE |-> tx_byte == 8'd0)
		else $error("tx byte set without a tx kind");

endmodule

bind i2c_master_register_read_sequencer i2crs_checker u_i2crs_checker (.*);
